/* design/dct2_pkg.sv */
// Shared types, constants and cosine tables for the orthonormal DCT-II core.
// No dependencies; imported by the controller, the datapath and the top level.
package dct2_pkg;

    // Transform size limits; the cosine table below is built for this size
    localparam int MAX_POINTS_LOG2 = 6;
    localparam int MAX_POINTS      = 1 << MAX_POINTS_LOG2;
    localparam int PTS_W           = 3;
    localparam int IDX_W           = MAX_POINTS_LOG2;
    localparam int CNT_W           = MAX_POINTS_LOG2 + 1;

    // Word field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 20;
    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((COEF_W + IDX_W + 7) / 8) * 8;

    // Cosine phase: angle m * pi / (2 * MAX_POINTS), m modulo 4 * MAX_POINTS
    localparam int PHASE_W = MAX_POINTS_LOG2 + 2;
    localparam int QIDX_W  = MAX_POINTS_LOG2 + 1;
    localparam int QCOS_W  = 16;
    localparam int COS_W   = QCOS_W + 1;

    // Datapath widths
    localparam int PROD_W   = SAMPLE_W + COS_W;
    localparam int ACC_W    = PROD_W + MAX_POINTS_LOG2;
    localparam int MAG_W    = ACC_W - 1;
    localparam int SPLIT_W  = (MAG_W + 1) / 2;
    localparam int HALF_W   = 15;
    localparam int SPROD_W  = SPLIT_W + HALF_W;
    localparam int SCALE_W  = MAG_W + HALF_W;
    localparam int SUMR_W   = SCALE_W + 1;
    localparam int SH_W     = 6;
    localparam int RND_W    = SUMR_W - 15;

    // sqrt(1/2) in Q0.15 and the rounding shift bases
    localparam logic [HALF_W-1:0] SQRT_HALF_Q15   = 15'd23170;
    localparam logic [SH_W-1:0]   SHIFT_EVEN_BASE = 6'd15;
    localparam logic [SH_W-1:0]   SHIFT_ODD_BASE  = 6'd30;

    // Saturation limits of the coefficient magnitude
    localparam logic [COEF_W-1:0] COEF_POS_MAG = 20'h7FFFF;
    localparam logic [COEF_W-1:0] COEF_NEG_MAG = 20'h80000;

    // Controller states
    typedef enum logic [2:0] {
        S_COLLECT,
        S_ISSUE,
        S_DRAIN,
        S_MAG,
        S_SCALE,
        S_SUM,
        S_ROUND,
        S_EMIT
    } dct2_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             issue;
        logic             issue_first;
        logic             issue_last;
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] k;
        logic             k_last;
        logic [PTS_W-1:0] points_log2;
        logic             mag_en;
        logic             scale_en;
        logic             sum_en;
        logic             round_en;
        logic             out_load;
    } dct2_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic mac_done;
        logic out_free;
    } dct2_sts_t;

    // Quarter-wave cosine, round(32768 * cos(pi * q / (2 * MAX_POINTS))), q = 0..MAX_POINTS
    function automatic logic [QCOS_W-1:0] quarter_cos(input logic [QIDX_W-1:0] q);
        logic [QCOS_W-1:0] r;
        case (q)
            7'd0:  r = 16'd32768;
            7'd1:  r = 16'd32758;
            7'd2:  r = 16'd32729;
            7'd3:  r = 16'd32679;
            7'd4:  r = 16'd32610;
            7'd5:  r = 16'd32522;
            7'd6:  r = 16'd32413;
            7'd7:  r = 16'd32286;
            7'd8:  r = 16'd32138;
            7'd9:  r = 16'd31972;
            7'd10: r = 16'd31786;
            7'd11: r = 16'd31581;
            7'd12: r = 16'd31357;
            7'd13: r = 16'd31114;
            7'd14: r = 16'd30853;
            7'd15: r = 16'd30572;
            7'd16: r = 16'd30274;
            7'd17: r = 16'd29957;
            7'd18: r = 16'd29622;
            7'd19: r = 16'd29269;
            7'd20: r = 16'd28899;
            7'd21: r = 16'd28511;
            7'd22: r = 16'd28106;
            7'd23: r = 16'd27684;
            7'd24: r = 16'd27246;
            7'd25: r = 16'd26791;
            7'd26: r = 16'd26320;
            7'd27: r = 16'd25833;
            7'd28: r = 16'd25330;
            7'd29: r = 16'd24812;
            7'd30: r = 16'd24279;
            7'd31: r = 16'd23732;
            7'd32: r = 16'd23170;
            7'd33: r = 16'd22595;
            7'd34: r = 16'd22006;
            7'd35: r = 16'd21403;
            7'd36: r = 16'd20788;
            7'd37: r = 16'd20160;
            7'd38: r = 16'd19520;
            7'd39: r = 16'd18868;
            7'd40: r = 16'd18205;
            7'd41: r = 16'd17531;
            7'd42: r = 16'd16846;
            7'd43: r = 16'd16151;
            7'd44: r = 16'd15447;
            7'd45: r = 16'd14733;
            7'd46: r = 16'd14010;
            7'd47: r = 16'd13279;
            7'd48: r = 16'd12540;
            7'd49: r = 16'd11793;
            7'd50: r = 16'd11039;
            7'd51: r = 16'd10279;
            7'd52: r = 16'd9512;
            7'd53: r = 16'd8740;
            7'd54: r = 16'd7962;
            7'd55: r = 16'd7180;
            7'd56: r = 16'd6393;
            7'd57: r = 16'd5602;
            7'd58: r = 16'd4808;
            7'd59: r = 16'd4011;
            7'd60: r = 16'd3212;
            7'd61: r = 16'd2411;
            7'd62: r = 16'd1608;
            7'd63: r = 16'd804;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // Full-circle cosine in Q1.15 by folding onto the quarter wave
    function automatic logic signed [COS_W-1:0] full_cos(input logic [PHASE_W-1:0] m);
        logic [QIDX_W-1:0] q;
        logic              neg;
        logic [COS_W-1:0]  mag;
        if (m <= PHASE_W'(MAX_POINTS)) begin
            q   = QIDX_W'(m);
            neg = 1'b0;
        end
        else if (m <= PHASE_W'(2 * MAX_POINTS)) begin
            q   = QIDX_W'(PHASE_W'(2 * MAX_POINTS) - m);
            neg = 1'b1;
        end
        else if (m < PHASE_W'(3 * MAX_POINTS)) begin
            q   = QIDX_W'(m - PHASE_W'(2 * MAX_POINTS));
            neg = 1'b1;
        end
        else begin
            q   = QIDX_W'(~m + PHASE_W'(1));
            neg = 1'b0;
        end
        mag = {1'b0, quarter_cos(q)};
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

/* design/dct_type2_orthonormal_core.sv */
// Orthonormal DCT-II core, top level: controller plus datapath with stream ports.
// Depends on dct2_pkg, dct2_ctrl, dct2_datapath (and dct2_ram below it).
//
// Collects N = 2^points_log2 signed 16-bit samples (one word each on the slave side)
// and, after the N-th sample, sends N coefficients F[0..N-1] in order on the master
// side, with coef_index and tlast on F[N-1]. Samples are taken at one word per cycle;
// each coefficient is then formed by the single multiply-accumulate pipeline that reads
// one stored sample per cycle, its drain, and five scaling, rounding and output steps.
// No sample is taken while coefficients are being computed. Writing points_log2
// (values above 6 read as 6) discards any partial block; write it only while the
// core is idle. There is no clearing pass after reset.
module dct_type2_orthonormal_core
    import dct2_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Sample words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] sample
    // Coefficient words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [19:0] coefficient, [25:20] coef_index
    output logic                   m_tlast,   // last_coef
    // Length register
    input  logic                   cfg_we,
    input  logic [PTS_W-1:0]       cfg_wdata  // points_log2
);

    dct2_cmd_t cmd;
    dct2_sts_t sts;

    // Sequencing
    dct2_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic and storage
    dct2_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (s_tdata[SAMPLE_W-1:0]),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* design/dct2_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module dct2_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/dct2_ctrl.sv */
// Controller for the DCT-II core: sample collection, coefficient sequencing,
// length register. Depends on dct2_pkg; drives dct2_datapath by command struct.
module dct2_ctrl
    import dct2_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             cfg_we,
    input  logic [PTS_W-1:0] cfg_wdata,
    input  dct2_sts_t        sts,
    output dct2_cmd_t        cmd
);

    dct2_state_t      state_reg, state_next;
    logic [PTS_W-1:0] points_reg, points_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] last_idx;

    // Highest index of the current block, N - 1
    assign last_idx = IDX_W'((CNT_W'(1) << points_reg) - CNT_W'(1));

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_COLLECT;
            points_reg <= PTS_W'(3);
            count_reg  <= '0;
            n_reg      <= '0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            points_reg <= points_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        points_next = points_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        s_tready    = 1'b0;

        cmd             = '0;
        cmd.wr_addr     = count_reg;
        cmd.n           = n_reg;
        cmd.k           = k_reg;
        cmd.k_last      = (k_reg == last_idx);
        cmd.points_log2 = points_reg;
        cmd.issue_first = (n_reg == '0);
        cmd.issue_last  = (n_reg == last_idx);

        unique case (state_reg)
            S_COLLECT:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.wr_en = 1'b1;
                    if (count_reg == last_idx)
                    begin
                        count_next = '0;
                        n_next     = '0;
                        k_next     = '0;
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        count_next = count_reg + IDX_W'(1);
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (n_reg == last_idx)
                begin
                    n_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    n_next = n_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (sts.mac_done)
                begin
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                cmd.mag_en = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (k_reg == last_idx)
                    begin
                        state_next = S_COLLECT;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase

        // Length write: saturate and drop the partial block
        if (cfg_we)
        begin
            points_next = (cfg_wdata > PTS_W'(MAX_POINTS_LOG2)) ? PTS_W'(MAX_POINTS_LOG2)
                                                                 : cfg_wdata;
            count_next  = '0;
        end
    end

`ifndef ASSERT_OFF
    // The accumulator only finishes while the controller waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.mac_done |-> state_reg == S_DRAIN)
        else $error("mac_done outside drain state");

    // Never overwrite a result word that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output loaded while stalled");

    // A block of samples ends with a run of issues
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COLLECT) && s_tvalid && (count_reg == last_idx) && !cfg_we
        |=> state_reg == S_ISSUE && n_reg == '0 && k_reg == '0)
        else $error("block end did not start coefficient k = 0");
`endif

endmodule

/* design/dct2_datapath.sv */
// Datapath for the DCT-II core: sample store, cosine multiply-accumulate pipeline,
// sqrt(1/2) scaling, rounding, saturation and output register. Depends on dct2_pkg, dct2_ram.
module dct2_datapath
    import dct2_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SAMPLE_W-1:0]    sample,
    input  dct2_cmd_t              cmd,
    output dct2_sts_t              sts,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    // Sample store
    logic [SAMPLE_W-1:0] rdata;

    dct2_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (cmd.wr_addr),
        .wdata (sample),
        .re    (cmd.issue),
        .raddr (cmd.n),
        .rdata (rdata)
    );

    // Phase of x[n] for coefficient k: ((2n+1) * k) << (MAX - p), modulo full circle
    logic [IDX_W:0]                 odd_n;
    logic [2*IDX_W:0]               phase_prod;
    logic [PTS_W-1:0]               phase_sh;
    logic [2*IDX_W+MAX_POINTS_LOG2:0] phase_wide;
    logic [PHASE_W-1:0]             phase;

    assign odd_n      = {cmd.n, 1'b1};
    assign phase_prod = (2*IDX_W+1)'(odd_n) * (2*IDX_W+1)'(cmd.k);
    assign phase_sh   = PTS_W'(MAX_POINTS_LOG2) - cmd.points_log2;
    assign phase_wide = (2*IDX_W+MAX_POINTS_LOG2+1)'(phase_prod) << phase_sh;
    assign phase      = phase_wide[PHASE_W-1:0];

    // Multiply-accumulate pipeline registers
    logic                       v1_reg, v2_reg, v3_reg;
    logic                       first1_reg, first2_reg, first3_reg;
    logic                       last1_reg, last2_reg, last3_reg;
    logic [PHASE_W-1:0]         phase1_reg;
    logic signed [COS_W-1:0]    cos2_reg;
    logic signed [SAMPLE_W-1:0] samp2_reg;
    logic signed [PROD_W-1:0]   prod3_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       done_reg;

    // Advance the valid and tag line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= cmd.issue;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg && last3_reg;
        end
    end

    // Accumulate from the first product of a coefficient
    assign acc_next = first3_reg ? ACC_W'(prod3_reg) : acc_reg + ACC_W'(prod3_reg);

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        first1_reg <= cmd.issue_first;
        last1_reg  <= cmd.issue_last;
        phase1_reg <= phase;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        cos2_reg   <= full_cos(phase1_reg);
        samp2_reg  <= $signed(rdata);
        first3_reg <= first2_reg;
        last3_reg  <= last2_reg;
        prod3_reg  <= PROD_W'(samp2_reg) * PROD_W'(cos2_reg);
        if (v3_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Scale selection: h = p for k = 0, p - 1 otherwise
    logic [PTS_W-1:0] h;
    logic             h_odd;
    logic [SH_W-1:0]  sh;

    assign h     = (cmd.k == '0) ? cmd.points_log2 : cmd.points_log2 - PTS_W'(1);
    assign h_odd = h[0];
    assign sh    = (h_odd ? SHIFT_ODD_BASE : SHIFT_EVEN_BASE) + SH_W'(h >> 1);

    // Post-processing registers
    logic                 neg_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [SPROD_W-1:0]   lo_prod_reg, hi_prod_reg;
    logic [SCALE_W-1:0]   scaled_reg;
    logic [RND_W-1:0]     rnd_reg;
    logic [SUMR_W-1:0]    half;
    logic [SUMR_W-1:0]    rounded;

    assign half    = SUMR_W'(1) << (sh - SH_W'(1));
    assign rounded = (SUMR_W'(scaled_reg) + half) >> sh;

    // Magnitude, split scaling, sum and rounding, one step per command
    always_ff @(posedge clk)
    begin
        if (cmd.mag_en)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
        end
        if (cmd.scale_en)
        begin
            lo_prod_reg <= SPROD_W'(mag_reg[SPLIT_W-1:0]) * SPROD_W'(SQRT_HALF_Q15);
            hi_prod_reg <= SPROD_W'(mag_reg[MAG_W-1:SPLIT_W]) * SPROD_W'(SQRT_HALF_Q15);
        end
        if (cmd.sum_en)
        begin
            scaled_reg <= h_odd ? (SCALE_W'(hi_prod_reg) << SPLIT_W) + SCALE_W'(lo_prod_reg)
                                : SCALE_W'(mag_reg);
        end
        if (cmd.round_en)
        begin
            rnd_reg <= RND_W'(rounded);
        end
    end

    // Saturate and restore the sign
    logic [COEF_W-1:0] cap;
    logic [COEF_W-1:0] coef;

    always_comb
    begin
        if (neg_reg)
        begin
            cap = (rnd_reg > RND_W'(COEF_NEG_MAG)) ? COEF_NEG_MAG : COEF_W'(rnd_reg);
        end
        else
        begin
            cap = (rnd_reg > RND_W'(COEF_POS_MAG)) ? COEF_POS_MAG : COEF_W'(rnd_reg);
        end
        coef = neg_reg ? -cap : cap;
    end

    // Output word register
    logic              out_valid_reg;
    logic [COEF_W-1:0] out_coef_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_coef_reg <= coef;
            out_idx_reg  <= cmd.k;
            out_last_reg <= cmd.k_last;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = OUT_TDATA_W'({out_idx_reg, out_coef_reg});
    assign m_tlast      = out_last_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.mac_done = done_reg;

`ifndef ASSERT_OFF
    // After the last issue, done_reg rises once the product has passed the v1, v2 and v3 stages
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue && cmd.issue_last |-> ##4 done_reg)
        else $error("accumulator did not finish on time");

    // A loaded result word is presented on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg && out_idx_reg == $past(cmd.k))
        else $error("output word not presented after load");

    // Post-processing never runs while products are still in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mag_en || cmd.scale_en || cmd.sum_en || cmd.round_en)
        |-> !v1_reg && !v2_reg && !v3_reg)
        else $error("scaling overlaps accumulation");
`endif

endmodule
